@@ rtl/sfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Sphere frustum cull package
// Widths, register codes and plane field helpers shared by the cull core
// and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfc_pkg;

  // Geometry
  localparam int NumAxes   = 3;
  localparam int NumPlanes = 6;
  localparam int NumStages = 5;

  // Arithmetic widths
  localparam int CoordW     = 32;  // signed Q16.16 inputs
  localparam int ProdW      = 64;  // 32 x 32 products
  localparam int WorldW     = 66;  // world coordinate, Q.32 fraction
  localparam int RadW       = 64;  // world radius, Q.32 fraction
  localparam int PlaneW     = 64;  // packed plane register
  localparam int NormW      = 16;  // plane normal and offset fields
  localparam int PlaneProdW = WorldW + NormW;  // Q.46 fraction
  localparam int SumW       = 85;  // distance plus radius, Q.46 fraction

  // Scaling to the common Q.46 fraction
  localparam int TransShift = 16;
  localparam int OffShift   = 42;
  localparam int RadShift   = 14;

  // Configuration port
  localparam int CfgIdxW = 3;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [PlaneW-1:0]  plane_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PLANE_LEFT   = 3'd0,
    CFG_PLANE_RIGHT  = 3'd1,
    CFG_PLANE_BOTTOM = 3'd2,
    CFG_PLANE_TOP    = 3'd3,
    CFG_PLANE_NEAR   = 3'd4,
    CFG_PLANE_FAR    = 3'd5
  } cfg_idx_e;

  // Normal component of a packed plane: axis 0 is nx in the top field.
  function automatic logic signed [NormW-1:0] plane_norm(plane_t pl, int axis);
    return $signed(pl[PlaneW-1-NormW*axis -: NormW]);
  endfunction

  function automatic logic signed [NormW-1:0] plane_off(plane_t pl);
    return $signed(pl[NormW-1:0]);
  endfunction

endpackage

@@ rtl/sphere_frustum_cull_core.sv @@
// ----------------------------------------------------------------------------
// Sphere frustum cull core
// Throughput: one mesh per cycle while the output is not held; each of
// the five stages holds one request and moves whenever the stage after
// it is empty or moving. Reset: valid bits and plane registers clear;
// with zero planes every distance is zero, so a mesh with a transform
// shows visible unless its world radius is < 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sphere_frustum_cull_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  sfc_pkg::cfg_idx_t                   cfg_idx_i,
  input  sfc_pkg::plane_t                     cfg_data_i,
  // Request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                has_transform_i,
  input  logic [63:0]                         row0_ab_i,
  input  logic [63:0]                         row0_cd_i,
  input  logic [63:0]                         row1_ab_i,
  input  logic [63:0]                         row1_cd_i,
  input  logic [63:0]                         row2_ab_i,
  input  logic [63:0]                         row2_cd_i,
  input  logic [63:0]                         center_xy_i,
  input  logic [63:0]                         center_z_radius_i,
  input  logic [63:0]                         scale_xy_i,
  input  logic signed [sfc_pkg::CoordW-1:0]   scale_z_i,
  // Result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                visible_o
);

  // --------------------------------------------------------------------------
  // Plane registers. Software must write them only while the pipeline is
  // empty, which the block itself does not enforce; the later stages read
  // them directly. Indexes above the far plane are dropped.
  // --------------------------------------------------------------------------
  sfc_pkg::plane_t planes_q [sfc_pkg::NumPlanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < sfc_pkg::NumPlanes; p++) begin
        planes_q[p] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i <= sfc_pkg::CFG_PLANE_FAR)) begin
      planes_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. Each stage holds one request and loads when it is empty or
  // when its own content moves on. A bubble anywhere is squeezed out, so the
  // input only stalls when all five stages are full and the output is held.
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: unpack the request, form the nine matrix-by-center products
  // (each exact in 64 bits) and pick the largest scale component.
  // --------------------------------------------------------------------------
  logic signed [sfc_pkg::CoordW-1:0] m_a [sfc_pkg::NumAxes][sfc_pkg::NumAxes];
  logic signed [sfc_pkg::CoordW-1:0] m_t [sfc_pkg::NumAxes];
  logic signed [sfc_pkg::CoordW-1:0] cen [sfc_pkg::NumAxes];
  logic signed [sfc_pkg::CoordW-1:0] scl_x, scl_y, scl_xy_max, scl_max;

  assign m_a[0][0] = $signed(row0_ab_i[63:32]);
  assign m_a[0][1] = $signed(row0_ab_i[31:0]);
  assign m_a[0][2] = $signed(row0_cd_i[63:32]);
  assign m_t[0]    = $signed(row0_cd_i[31:0]);
  assign m_a[1][0] = $signed(row1_ab_i[63:32]);
  assign m_a[1][1] = $signed(row1_ab_i[31:0]);
  assign m_a[1][2] = $signed(row1_cd_i[63:32]);
  assign m_t[1]    = $signed(row1_cd_i[31:0]);
  assign m_a[2][0] = $signed(row2_ab_i[63:32]);
  assign m_a[2][1] = $signed(row2_ab_i[31:0]);
  assign m_a[2][2] = $signed(row2_cd_i[63:32]);
  assign m_t[2]    = $signed(row2_cd_i[31:0]);

  assign cen[0] = $signed(center_xy_i[63:32]);
  assign cen[1] = $signed(center_xy_i[31:0]);
  assign cen[2] = $signed(center_z_radius_i[63:32]);

  assign scl_x      = $signed(scale_xy_i[63:32]);
  assign scl_y      = $signed(scale_xy_i[31:0]);
  assign scl_xy_max = (scl_y > scl_x) ? scl_y : scl_x;
  assign scl_max    = (scale_z_i > scl_xy_max) ? scale_z_i : scl_xy_max;

  logic signed [sfc_pkg::ProdW-1:0] mp1_d [sfc_pkg::NumAxes][sfc_pkg::NumAxes];
  logic signed [sfc_pkg::ProdW-1:0] mp1_q [sfc_pkg::NumAxes][sfc_pkg::NumAxes];
  logic signed [sfc_pkg::CoordW-1:0] tr1_q [sfc_pkg::NumAxes];
  logic signed [sfc_pkg::CoordW-1:0] smax1_q;
  logic [sfc_pkg::CoordW-1:0]        rad1_q;
  logic                              ht1_q;

  always_comb begin
    for (int r = 0; r < sfc_pkg::NumAxes; r++) begin
      for (int c = 0; c < sfc_pkg::NumAxes; c++) begin
        mp1_d[r][c] = sfc_pkg::ProdW'(m_a[r][c]) * sfc_pkg::ProdW'(cen[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mp1_q   <= mp1_d;
      tr1_q   <= m_t;
      smax1_q <= scl_max;
      rad1_q  <= center_z_radius_i[31:0];
      ht1_q   <= has_transform_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: world center per axis as the sum of the three products and the
  // translation moved to Q.32, and the world radius as radius times the
  // largest scale. A negative largest scale yields a negative radius, which
  // the distance test takes as it is. The radius product always fits in
  // 64 signed bits, since the radius is below 2^32 and the scale is a
  // signed 32-bit value.
  // --------------------------------------------------------------------------
  logic signed [sfc_pkg::WorldW-1:0] w2_d [sfc_pkg::NumAxes];
  logic signed [sfc_pkg::WorldW-1:0] w2_q [sfc_pkg::NumAxes];
  logic signed [sfc_pkg::RadW-1:0]   rad_full;
  logic signed [sfc_pkg::RadW-1:0]   rad2_q;
  logic                              ht2_q;

  always_comb begin
    for (int r = 0; r < sfc_pkg::NumAxes; r++) begin
      w2_d[r] = sfc_pkg::WorldW'(mp1_q[r][0]) + sfc_pkg::WorldW'(mp1_q[r][1])
              + sfc_pkg::WorldW'(mp1_q[r][2])
              + (sfc_pkg::WorldW'(tr1_q[r]) <<< sfc_pkg::TransShift);
    end
  end

  assign rad_full = sfc_pkg::RadW'($signed({1'b0, rad1_q}))
                  * sfc_pkg::RadW'(smax1_q);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      w2_q   <= w2_d;
      rad2_q <= rad_full;
      ht2_q  <= ht1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: eighteen normal-by-coordinate products, one per plane and axis.
  // Each is a 66 x 16 signed multiply, exact at Q.46 fraction.
  // --------------------------------------------------------------------------
  logic signed [sfc_pkg::PlaneProdW-1:0] pp3_d [sfc_pkg::NumPlanes][sfc_pkg::NumAxes];
  logic signed [sfc_pkg::PlaneProdW-1:0] pp3_q [sfc_pkg::NumPlanes][sfc_pkg::NumAxes];
  logic signed [sfc_pkg::RadW-1:0]       rad3_q;
  logic                                  ht3_q;

  always_comb begin
    for (int p = 0; p < sfc_pkg::NumPlanes; p++) begin
      for (int k = 0; k < sfc_pkg::NumAxes; k++) begin
        pp3_d[p][k] = sfc_pkg::PlaneProdW'(w2_q[k])
                    * sfc_pkg::PlaneProdW'(sfc_pkg::plane_norm(planes_q[p], k));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      pp3_q  <= pp3_d;
      rad3_q <= rad2_q;
      ht3_q  <= ht2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: two partial sums per plane. The first adds the x and y terms,
  // the second the z term, the offset and the radius, all at Q.46 fraction.
  // --------------------------------------------------------------------------
  logic signed [sfc_pkg::SumW-1:0] sa4_d [sfc_pkg::NumPlanes];
  logic signed [sfc_pkg::SumW-1:0] sb4_d [sfc_pkg::NumPlanes];
  logic signed [sfc_pkg::SumW-1:0] sa4_q [sfc_pkg::NumPlanes];
  logic signed [sfc_pkg::SumW-1:0] sb4_q [sfc_pkg::NumPlanes];
  logic                            ht4_q;

  always_comb begin
    for (int p = 0; p < sfc_pkg::NumPlanes; p++) begin
      sa4_d[p] = sfc_pkg::SumW'(pp3_q[p][0]) + sfc_pkg::SumW'(pp3_q[p][1]);
      sb4_d[p] = sfc_pkg::SumW'(pp3_q[p][2])
               + (sfc_pkg::SumW'(sfc_pkg::plane_off(planes_q[p])) <<< sfc_pkg::OffShift)
               + (sfc_pkg::SumW'(rad3_q) <<< sfc_pkg::RadShift);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      sa4_q <= sa4_d;
      sb4_q <= sb4_d;
      ht4_q <= ht3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: distance plus radius per plane. A negative sum means the sphere
  // lies wholly outside that plane. A mesh without a transform is never
  // visible.
  // --------------------------------------------------------------------------
  logic signed [sfc_pkg::SumW-1:0] dsum [sfc_pkg::NumPlanes];
  logic [sfc_pkg::NumPlanes-1:0]   outside;
  logic                            vis5_q;

  always_comb begin
    for (int p = 0; p < sfc_pkg::NumPlanes; p++) begin
      dsum[p]    = sa4_q[p] + sb4_q[p];
      outside[p] = dsum[p][sfc_pkg::SumW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      vis5_q <= ht4_q && !(|outside);
    end
  end

  assign out_valid_o = v5_q;
  assign visible_o   = vis5_q;

endmodule

@@ rtl/sfc_checker.sv @@
// ----------------------------------------------------------------------------
// Sphere frustum cull checker
// Port-level checks on the cull core: request bookkeeping and stall behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic visible_o
);

  logic       in_acc, out_acc;
  logic [2:0] cnt_q, cnt_d;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Requests accepted but not yet delivered.
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 3'd1;
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A held result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(visible_o))
    else $error("held result changed");

  // The input only stalls when the output is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output was free");

  // No result without an outstanding request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 3'd0)
    else $error("result without a request");

  // The pipeline never holds more requests than it has stages.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(sfc_pkg::NumStages))
    else $error("more requests in flight than stages");

endmodule

bind sphere_frustum_cull_core sfc_checker u_sfc_checker (.*);

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Sphere frustum cull core testbench
// Streams mesh requests through the cull core under several plane settings
// and idle mixes, predicts each visible flag with exact wide arithmetic and
// compares every result in order against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sfc_pkg::*;

  // One mesh request as it appears on the request ports.
  typedef struct packed {
    logic        has_xform;
    logic [63:0] r0_ab;
    logic [63:0] r0_cd;
    logic [63:0] r1_ab;
    logic [63:0] r1_cd;
    logic [63:0] r2_ab;
    logic [63:0] r2_cd;
    logic [63:0] ctr_xy;
    logic [63:0] ctr_z_rad;
    logic [63:0] scl_xy;
    logic [31:0] scl_z;
  } mesh_req_t;

  // Kinds of plane setting that the run goes through.
  typedef enum int {
    PL_BOX,
    PL_TILT,
    PL_EXTREME,
    PL_NOISE
  } plane_kind_e;

  // Indexes past the last plane register; writes to them must be ignored.
  localparam cfg_idx_t CfgSpareLo = 3'd6;
  localparam cfg_idx_t CfgSpareHi = 3'd7;

  localparam int QOne       = 65536;  // 1.0 in Q16.16
  localparam int NormOne    = 16384;  // 1.0 in Q1.14
  localparam int OffOne     = 16;     // 1.0 in Q11.4
  localparam int IdleNone   = 0;
  localparam int IdleHeavy  = 46;
  localparam int IdleBoth   = 14;
  localparam int HoldCycles = 80;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        cfg_we   = 1'b0;
  cfg_idx_t    cfg_idx  = '0;
  plane_t      cfg_data = '0;

  logic        in_valid        = 1'b0;
  wire         in_stall;
  logic        has_transform   = 1'b0;
  logic [63:0] row0_ab         = '0;
  logic [63:0] row0_cd         = '0;
  logic [63:0] row1_ab         = '0;
  logic [63:0] row1_cd         = '0;
  logic [63:0] row2_ab         = '0;
  logic [63:0] row2_cd         = '0;
  logic [63:0] center_xy       = '0;
  logic [63:0] center_z_radius = '0;
  logic [63:0] scale_xy        = '0;
  logic signed [CoordW-1:0] scale_z = '0;

  wire         out_valid;
  logic        out_stall = 1'b0;
  wire         visible;

  // Shadow copy of the plane registers, updated as the writes go out.
  plane_t    plane_regs [NumPlanes];
  mesh_req_t mesh_backlog [$];   // requests waiting to be offered
  logic      vis_expected [$];   // predicted flags of accepted requests

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asks      = 0;
  int holds_done     = 0;
  logic hold_on      = 1'b0;

  int n_errors  = 0;
  int n_meshes  = 0;
  int n_results = 0;
  int n_shown   = 0;

  sphere_frustum_cull_core u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .has_transform_i   (has_transform),
    .row0_ab_i         (row0_ab),
    .row0_cd_i         (row0_cd),
    .row1_ab_i         (row1_ab),
    .row1_cd_i         (row1_cd),
    .row2_ab_i         (row2_ab),
    .row2_cd_i         (row2_cd),
    .center_xy_i       (center_xy),
    .center_z_radius_i (center_z_radius),
    .scale_xy_i        (scale_xy),
    .scale_z_i         (scale_z),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .visible_o         (visible)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Sign-extends a field into the 128-bit working width. All sums below are
  // carried at that width, which is far more than the largest distance needs,
  // so nothing rounds or wraps.
  function automatic logic signed [127:0] widen(logic signed [31:0] v);
    logic signed [127:0] w;
    w = v;
    return w;
  endfunction

  // Works out the visible flag of one mesh against the current planes. The
  // world center comes out at a Q.32 fraction; multiplying by a Q1.14 normal
  // brings it to Q.46, where the offset and the scaled radius are lined up
  // before the sign test.
  function automatic logic predict_visible(mesh_req_t m);
    logic [63:0]         ab [NumAxes];
    logic [63:0]         cd [NumAxes];
    logic signed [127:0] world [NumAxes];
    logic signed [127:0] cx, cy, cz, rad, dval;
    logic signed [31:0]  s_x, s_y, s_z, s_max;
    if (!m.has_xform) return 1'b0;
    ab = '{m.r0_ab, m.r1_ab, m.r2_ab};
    cd = '{m.r0_cd, m.r1_cd, m.r2_cd};
    cx = widen($signed(m.ctr_xy[63:32]));
    cy = widen($signed(m.ctr_xy[31:0]));
    cz = widen($signed(m.ctr_z_rad[63:32]));
    for (int a = 0; a < NumAxes; a++) begin
      world[a] = widen($signed(ab[a][63:32])) * cx + widen($signed(ab[a][31:0])) * cy
               + widen($signed(cd[a][63:32])) * cz
               + (widen($signed(cd[a][31:0])) <<< TransShift);
    end
    // The largest scale is taken as signed, so a negative one gives a
    // negative radius and the test is applied as it stands.
    s_x = $signed(m.scl_xy[63:32]);
    s_y = $signed(m.scl_xy[31:0]);
    s_z = $signed(m.scl_z);
    s_max = s_x;
    if (s_y > s_max) s_max = s_y;
    if (s_z > s_max) s_max = s_z;
    rad = ($signed({96'd0, m.ctr_z_rad[31:0]}) * widen(s_max)) <<< RadShift;
    for (int p = 0; p < NumPlanes; p++) begin
      dval = world[0] * widen($signed(plane_regs[p][63:48]))
           + world[1] * widen($signed(plane_regs[p][47:32]))
           + world[2] * widen($signed(plane_regs[p][31:16]))
           + (widen($signed(plane_regs[p][15:0])) <<< OffShift)
           + rad;
      // Only strictly below minus the radius culls; touching stays visible.
      if (dval < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic signed [31:0] rand_fix(int unsigned mag);
    int v;
    v = int'($urandom_range(2 * mag)) - int'(mag);
    return v;
  endfunction

  function automatic plane_t pack_plane(int nx, int ny, int nz, int off);
    return {16'(nx), 16'(ny), 16'(nz), 16'(off)};
  endfunction

  // Identity model matrix, equal scales on all three axes.
  function automatic mesh_req_t ident_req(int cx, int cy, int cz, int radius, int scl);
    mesh_req_t m;
    m.has_xform = 1'b1;
    m.r0_ab     = {32'(QOne), 32'd0};
    m.r0_cd     = '0;
    m.r1_ab     = {32'd0, 32'(QOne)};
    m.r1_cd     = '0;
    m.r2_ab     = '0;
    m.r2_cd     = {32'(QOne), 32'd0};
    m.ctr_xy    = {32'(cx), 32'(cy)};
    m.ctr_z_rad = {32'(cz), 32'(radius)};
    m.scl_xy    = {32'(scl), 32'(scl)};
    m.scl_z     = 32'(scl);
    return m;
  endfunction

  // Any bit pattern at all, mostly with a transform.
  function automatic mesh_req_t noise_req();
    mesh_req_t m;
    m = {1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    m.has_xform = ($urandom_range(9) != 0);
    return m;
  endfunction

  // A plausible mesh around a scene of half size h units: scales on the
  // diagonal, small shear elsewhere, center and translation within the scene,
  // so that roughly as many meshes straddle the planes as clear them.
  function automatic mesh_req_t shaped_req(int h);
    mesh_req_t          m;
    logic signed [31:0] sc [NumAxes];
    logic signed [31:0] mat [NumAxes][4];
    int unsigned        span;
    span = h * QOne;
    for (int a = 0; a < NumAxes; a++) begin
      sc[a] = $urandom_range(4 * QOne, QOne / 4);
      if ($urandom_range(19) == 0) sc[a] = -sc[a];
    end
    for (int r = 0; r < NumAxes; r++) begin
      for (int c = 0; c < NumAxes; c++) mat[r][c] = (r == c) ? sc[r] : rand_fix(QOne / 2);
      mat[r][3] = rand_fix(span);
    end
    m.has_xform = ($urandom_range(19) != 0);
    m.r0_ab     = {mat[0][0], mat[0][1]};
    m.r0_cd     = {mat[0][2], mat[0][3]};
    m.r1_ab     = {mat[1][0], mat[1][1]};
    m.r1_cd     = {mat[1][2], mat[1][3]};
    m.r2_ab     = {mat[2][0], mat[2][1]};
    m.r2_cd     = {mat[2][2], mat[2][3]};
    m.ctr_xy    = {rand_fix(span), rand_fix(span)};
    m.ctr_z_rad = {rand_fix(span), 32'($urandom_range(span / 2))};
    m.scl_xy    = {sc[0], sc[1]};
    m.scl_z     = sc[2];
    return m;
  endfunction

  // One register write. Called right after a rising edge; the enable is left
  // high so back-to-back writes need only one assignment per edge, and the
  // caller lowers it after the last one.
  task automatic write_plane(cfg_idx_t idx, plane_t val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx < NumPlanes) plane_regs[idx] = val;
    @(posedge clk_i);
  endtask

  task automatic load_planes(plane_kind_e kind, int h);
    plane_t pl [NumPlanes];
    int     h16;
    h16 = h * OffOne;
    for (int p = 0; p < NumPlanes; p++) begin
      case (kind)
        PL_TILT:    pl[p] = pack_plane(rand_fix(NormOne), rand_fix(NormOne),
                                       rand_fix(NormOne), rand_fix(h16));
        PL_EXTREME: pl[p] = (p % 2 == 0) ? 64'h7FFF_7FFF_7FFF_7FFF
                                         : 64'h8000_8000_8000_8000;
        PL_NOISE:   pl[p] = {$urandom, $urandom};
        default:    pl[p] = '0;
      endcase
    end
    // An axis-aligned box of half size h: each plane faces inward.
    if (kind == PL_BOX) begin
      pl[CFG_PLANE_LEFT]   = pack_plane(NormOne, 0, 0, h16);
      pl[CFG_PLANE_RIGHT]  = pack_plane(-NormOne, 0, 0, h16);
      pl[CFG_PLANE_BOTTOM] = pack_plane(0, NormOne, 0, h16);
      pl[CFG_PLANE_TOP]    = pack_plane(0, -NormOne, 0, h16);
      pl[CFG_PLANE_NEAR]   = pack_plane(0, 0, NormOne, h16);
      pl[CFG_PLANE_FAR]    = pack_plane(0, 0, -NormOne, h16);
    end
    for (int p = 0; p < NumPlanes; p++) write_plane(cfg_idx_t'(p), pl[p]);
    cfg_we <= 1'b0;
  endtask

  // Queues a mix of noise and shaped requests in random order under the
  // given idle rates and returns once the last of them has been accepted.
  task automatic run_batch(int n_noise, int n_shaped, int h, int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (n_noise + n_shaped > 0) begin
      if (n_shaped == 0 || (n_noise > 0 && $urandom_range(n_noise + n_shaped - 1) < n_noise)) begin
        mesh_backlog.push_back(noise_req());
        n_noise--;
      end else begin
        mesh_backlog.push_back(shaped_req(h));
        n_shaped--;
      end
    end
    while (mesh_backlog.size() != 0) @(posedge clk_i);
  endtask

  // Sender pauses until every predicted result has come back. Every request
  // yields a result, so an empty prediction queue means the core is idle.
  task automatic drain();
    while (mesh_backlog.size() != 0 || vis_expected.size() != 0) @(posedge clk_i);
  endtask

  task automatic flag_mismatch(string what);
    $display("ERROR @%0t: %s", $time, what);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: offers the head of the backlog, keeps it steady while the
  // core stalls, and predicts the flag at the edge where it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        vis_expected.push_back(predict_visible(mesh_backlog[0]));
        mesh_backlog.delete(0);
        n_meshes++;
      end
      // A stalled request stays on the ports untouched.
      if (!(in_valid && in_stall)) begin
        if (mesh_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid        <= 1'b1;
          has_transform   <= mesh_backlog[0].has_xform;
          row0_ab         <= mesh_backlog[0].r0_ab;
          row0_cd         <= mesh_backlog[0].r0_cd;
          row1_ab         <= mesh_backlog[0].r1_ab;
          row1_cd         <= mesh_backlog[0].r1_cd;
          row2_ab         <= mesh_backlog[0].r2_ab;
          row2_cd         <= mesh_backlog[0].r2_cd;
          center_xy       <= mesh_backlog[0].ctr_xy;
          center_z_radius <= mesh_backlog[0].ctr_z_rad;
          scale_xy        <= mesh_backlog[0].scl_xy;
          scale_z         <= mesh_backlog[0].scl_z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls, plus a long hold-off on request that lets the
  // five pipeline stages fill and push back on the request channel.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
  end

  initial begin : hold_off
    forever begin
      @(posedge clk_i);
      if (hold_asks != holds_done) begin
        hold_on <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_on <= 1'b0;
        holds_done++;
      end
    end
  end

  // Every taken result is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (vis_expected.size() == 0) begin
        flag_mismatch($sformatf("result visible=%0b with no request outstanding", visible));
      end else begin
        if (visible !== vis_expected[0]) begin
          flag_mismatch($sformatf("result %0d: visible %b, predicted %b",
                                  n_results, visible, vis_expected[0]));
        end
        vis_expected.delete(0);
      end
      n_results++;
      if (visible === 1'b1) n_shown++;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int h;
    for (int p = 0; p < NumPlanes; p++) plane_regs[p] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Planes at reset. Writes past the last register must leave them zero.
    write_plane(CfgSpareLo, '1);
    write_plane(CfgSpareHi, '1);
    cfg_we <= 1'b0;
    // No transform overrides everything else.
    mesh_backlog.push_back('0);
    mesh_backlog.push_back({1'b0, {19{32'hFFFF_FFFF}}});
    // All zero: zero radius, zero distances, visible.
    mesh_backlog.push_back({1'b1, {19{32'h0}}});
    // All ones: largest scale is minus one step, so the radius is negative.
    mesh_backlog.push_back({1'b1, {19{32'hFFFF_FFFF}}});
    // Field extremes, most positive and most negative.
    mesh_backlog.push_back({1'b1, {19{32'h7FFF_FFFF}}});
    mesh_backlog.push_back({1'b1, {19{32'h8000_0000}}});
    // Negative scale with zero radius stays visible; with a radius it culls.
    mesh_backlog.push_back(ident_req(0, 0, 0, 0, -QOne));
    mesh_backlog.push_back(ident_req(0, 0, 0, QOne, -QOne));
    // Largest scale taken from z alone.
    mesh_backlog.push_back(ident_req(0, 0, 0, QOne, -QOne));
    mesh_backlog[$].scl_z = QOne;
    run_batch(60, 0, 1, IdleNone, IdleNone);
    drain();

    // Box of half size 8: spheres exactly touching a plane from outside stay
    // visible, one step further out they are culled. Radius is 2 units.
    load_planes(PL_BOX, 8);
    mesh_backlog.push_back(ident_req(-10 * QOne, 0, 0, 2 * QOne, QOne));
    mesh_backlog.push_back(ident_req(-10 * QOne - 1, 0, 0, 2 * QOne, QOne));
    mesh_backlog.push_back(ident_req(0, 0, 10 * QOne, 2 * QOne, QOne));
    mesh_backlog.push_back(ident_req(0, 0, 10 * QOne + 1, 2 * QOne, QOne));
    // Negative radius: visible only while every distance is at least one unit.
    mesh_backlog.push_back(ident_req(-7 * QOne, 0, 0, QOne, -QOne));
    mesh_backlog.push_back(ident_req(-7 * QOne - 1, 0, 0, QOne, -QOne));
    mesh_backlog.push_back(ident_req(0, 0, 0, QOne, -QOne));
    run_batch(0, 80, 8, IdleNone, IdleNone);
    drain();

    h = $urandom_range(200, 4);
    load_planes(PL_BOX, h);
    run_batch(20, 130, h, IdleHeavy, IdleNone);
    drain();

    load_planes(PL_TILT, h);
    run_batch(10, 140, h, IdleNone, IdleHeavy);
    drain();

    write_plane(CfgSpareLo, {$urandom, $urandom});
    write_plane(CfgSpareHi, {$urandom, $urandom});
    load_planes(PL_EXTREME, h);
    run_batch(100, 50, h, IdleBoth, IdleBoth);
    drain();

    load_planes(PL_NOISE, h);
    run_batch(60, 40, h, IdleBoth, IdleBoth);
    drain();

    // Backpressure: the result side holds off while requests keep coming,
    // then the sender waits for a full drain before the last batch.
    h = $urandom_range(200, 4);
    load_planes(PL_BOX, h);
    hold_asks++;
    run_batch(0, 100, h, IdleNone, IdleNone);
    drain();
    run_batch(10, 40, h, IdleBoth, IdleBoth);
    drain();

    repeat (4 * NumStages) @(posedge clk_i);
    $display("Summary: %0d meshes sent, %0d results checked (%0d visible, %0d culled)",
             n_meshes, n_results, n_shown, n_results - n_shown);
    $display("Covered zero, box, tilted, extreme and random planes under four idle mixes.");
    if (n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("tb_top failed");
    end
    $finish;
  end

  // Far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d requests queued and %0d results outstanding",
             mesh_backlog.size(), vis_expected.size());
    $display("tb_top failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sfc_pkg.sv
rtl/sphere_frustum_cull_core.sv
rtl/sfc_checker.sv
dv/tb_top.sv
